// ----- design/tpma_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the two-port memory arbiter.
package tpma_pkg;

  localparam int PORT_W          = 64;
  localparam int REQ_DEPTH_DEF   = 8;
  localparam int RSP_DEPTH_DEF   = 8;
  localparam int TAG_DEPTH_DEF   = 8;
  localparam int WORD_WIDTH_DEF  = 64;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

// ----- design/tpma_fifo.sv -----
`timescale 1ns / 1ps
// Circular FIFO with head readout and count, one push and one pop per cycle.
module tpma_fifo #(
  parameter int DEPTH = tpma_pkg::REQ_DEPTH_DEF,
  parameter int WIDTH = tpma_pkg::WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tpma_pkg::fifo_ctl_t          ctl,
  input  logic [WIDTH-1:0]             wdata,
  output logic [WIDTH-1:0]             head_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    head_r;
  logic [AW-1:0]    head_nxt;
  logic [CW-1:0]    cnt_r;
  logic [SW-1:0]    tail_sum;
  logic [SW-1:0]    tail_wrap;
  logic [AW-1:0]    tail_idx;

  // head + count stays below twice the depth, so one subtract wraps it
  assign tail_sum  = SW'(head_r) + SW'(cnt_r);
  assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? (tail_sum - SW'(DEPTH)) : tail_sum;
  assign tail_idx  = tail_wrap[AW-1:0];
  assign head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : (head_r + AW'(1));

  assign head_data = mem[head_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (ctl.pop) begin
        head_r <= head_nxt;
      end
      cnt_r <= cnt_r + CW'(ctl.push) - CW'(ctl.pop);
    end
  end

endmodule

// ----- design/two_port_memory_arbiter.sv -----
`timescale 1ns / 1ps
// Two-requester round-robin memory arbiter: input register, one pass, result register.
// An accepted item is held in the input register, then its result is captured in the result register and strobed.
// Throughput: one item per cycle; busy is always low, the queue pointer update is one pass.
// Reset: queue heads and counts clear to empty and requester 0 is favored;
// queue contents are not cleared. The receiver cannot stall: out_valid lasts one cycle.
module two_port_memory_arbiter #(
  parameter int REQ_DEPTH  = tpma_pkg::REQ_DEPTH_DEF,
  parameter int RSP_DEPTH  = tpma_pkg::RSP_DEPTH_DEF,
  parameter int TAG_DEPTH  = tpma_pkg::TAG_DEPTH_DEF,
  parameter int WORD_WIDTH = tpma_pkg::WORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req0_valid,
  input  logic [tpma_pkg::PORT_W-1:0] in_req0_word,
  input  logic                        in_req1_valid,
  input  logic [tpma_pkg::PORT_W-1:0] in_req1_word,
  input  logic                        in_poll0,
  input  logic                        in_poll1,
  input  logic                        in_ram_ready,
  input  logic                        in_ram_rsp_valid,
  input  logic [tpma_pkg::PORT_W-1:0] in_ram_rsp_word,
  output logic                        out_valid,
  output logic                        out_room0,
  output logic                        out_room1,
  output logic                        out_fwd_valid,
  output logic [tpma_pkg::PORT_W-1:0] out_fwd_word,
  output logic                        out_fwd_source,
  output logic                        out_out0_valid,
  output logic [tpma_pkg::PORT_W-1:0] out_out0_word,
  output logic                        out_out1_valid,
  output logic [tpma_pkg::PORT_W-1:0] out_out1_word,
  output logic                        out_lost
);

  localparam int RCW = $clog2(REQ_DEPTH + 1);
  localparam int SCW = $clog2(RSP_DEPTH + 1);
  localparam int TCW = $clog2(TAG_DEPTH + 1);
  localparam int PW  = tpma_pkg::PORT_W;

  // input register
  logic                  stg_vld_r;
  logic                  req_vld_r  [2];
  logic [WORD_WIDTH-1:0] req_word_r [2];
  logic                  poll_r     [2];
  logic                  ram_ready_r;
  logic                  rsp_vld_r;
  logic [WORD_WIDTH-1:0] rsp_word_r;

  // queue status
  tpma_pkg::fifo_ctl_t   rq_ctl   [2];
  tpma_pkg::fifo_ctl_t   rsp_ctl  [2];
  tpma_pkg::fifo_ctl_t   tag_ctl;
  logic [RCW-1:0]        rq_cnt   [2];
  logic [WORD_WIDTH-1:0] rq_head  [2];
  logic [SCW-1:0]        rsp_cnt  [2];
  logic [WORD_WIDTH-1:0] rsp_head [2];
  logic [TCW-1:0]        tag_cnt;
  logic                  tag_head;

  // single-pass logic
  logic [RCW-1:0]        rq_cnt_enq  [2];
  logic [WORD_WIDTH-1:0] rq_word     [2];
  logic [SCW-1:0]        rsp_cnt_pol [2];
  logic                  room        [2];
  logic [TCW-1:0]        tag_cnt_rt;
  logic                  fwd_ok;
  logic                  fwd_v;
  logic                  fwd_src;
  logic                  fav_r;
  logic                  fav_nxt;
  logic                  lost_nxt;

  // result register
  logic                  out_valid_r;
  logic                  room0_r;
  logic                  room1_r;
  logic                  fwd_valid_r;
  logic [PW-1:0]         fwd_word_r;
  logic [PW-1:0]         fwd_word_nxt;
  logic                  fwd_source_r;
  logic                  got0_valid_r;
  logic [PW-1:0]         got0_word_r;
  logic [PW-1:0]         got0_word_nxt;
  logic                  got1_valid_r;
  logic [PW-1:0]         got1_word_r;
  logic [PW-1:0]         got1_word_nxt;
  logic                  lost_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    req_vld_r[0]  <= in_req0_valid;
    req_word_r[0] <= in_req0_word[WORD_WIDTH-1:0];
    req_vld_r[1]  <= in_req1_valid;
    req_word_r[1] <= in_req1_word[WORD_WIDTH-1:0];
    poll_r[0]     <= in_poll0;
    poll_r[1]     <= in_poll1;
    ram_ready_r   <= in_ram_ready;
    rsp_vld_r     <= in_ram_rsp_valid;
    rsp_word_r    <= in_ram_rsp_word[WORD_WIDTH-1:0];
  end

  for (genvar g = 0; g < 2; g++) begin : g_side
    tpma_fifo #(
      .DEPTH (REQ_DEPTH),
      .WIDTH (WORD_WIDTH)
    ) u_req_q (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (rq_ctl[g]),
      .wdata     (req_word_r[g]),
      .head_data (rq_head[g]),
      .count     (rq_cnt[g])
    );

    tpma_fifo #(
      .DEPTH (RSP_DEPTH),
      .WIDTH (WORD_WIDTH)
    ) u_rsp_q (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (rsp_ctl[g]),
      .wdata     (rsp_word_r),
      .head_data (rsp_head[g]),
      .count     (rsp_cnt[g])
    );
  end

  tpma_fifo #(
    .DEPTH (TAG_DEPTH),
    .WIDTH (1)
  ) u_tag_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tag_ctl),
    .wdata     (fwd_src),
    .head_data (tag_head),
    .count     (tag_cnt)
  );

  always_comb begin
    lost_nxt = 1'b0;

    // enqueue, then poll
    for (int s = 0; s < 2; s++) begin
      rq_ctl[s].push = stg_vld_r && req_vld_r[s] && (rq_cnt[s] != RCW'(REQ_DEPTH));
      rq_ctl[s].pop  = 1'b0;
      if (stg_vld_r && req_vld_r[s] && (rq_cnt[s] == RCW'(REQ_DEPTH))) begin
        lost_nxt = 1'b1;
      end
      rq_cnt_enq[s] = rq_cnt[s] + RCW'(rq_ctl[s].push);
      // an empty queue forwards the item that was just pushed
      rq_word[s] = (rq_cnt[s] == '0) ? req_word_r[s] : rq_head[s];

      rsp_ctl[s].pop  = stg_vld_r && poll_r[s] && (rsp_cnt[s] != '0);
      rsp_ctl[s].push = 1'b0;
      rsp_cnt_pol[s]  = rsp_cnt[s] - SCW'(rsp_ctl[s].pop);
    end

    // route the memory response to the owner at the tag head
    tag_ctl.pop  = stg_vld_r && rsp_vld_r && (tag_cnt != '0);
    tag_ctl.push = 1'b0;
    if (stg_vld_r && rsp_vld_r && (tag_cnt == '0)) begin
      lost_nxt = 1'b1;
    end
    if (tag_ctl.pop) begin
      if (rsp_cnt_pol[tag_head] != SCW'(RSP_DEPTH)) begin
        rsp_ctl[tag_head].push = 1'b1;
      end else begin
        lost_nxt = 1'b1;
      end
    end
    tag_cnt_rt = tag_cnt - TCW'(tag_ctl.pop);

    // forward, favored side first
    fwd_ok  = stg_vld_r && ram_ready_r && (tag_cnt_rt != TCW'(TAG_DEPTH));
    fwd_v   = 1'b0;
    fwd_src = 1'b0;
    fav_nxt = fav_r;
    if (fwd_ok) begin
      if (rq_cnt_enq[fav_r] != '0) begin
        fwd_v   = 1'b1;
        fwd_src = fav_r;
        fav_nxt = ~fav_r;
      end else if (rq_cnt_enq[~fav_r] != '0) begin
        fwd_v   = 1'b1;
        fwd_src = ~fav_r;
      end
    end
    if (fwd_v) begin
      rq_ctl[fwd_src].pop = 1'b1;
      tag_ctl.push        = 1'b1;
    end

    for (int s = 0; s < 2; s++) begin
      room[s] = (rq_cnt_enq[s] - RCW'(rq_ctl[s].pop)) != RCW'(REQ_DEPTH);
    end

    fwd_word_nxt  = fwd_v ? PW'(rq_word[fwd_src]) : '0;
    got0_word_nxt = rsp_ctl[0].pop ? PW'(rsp_head[0]) : '0;
    got1_word_nxt = rsp_ctl[1].pop ? PW'(rsp_head[1]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fav_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fav_r       <= fav_nxt;
      out_valid_r <= stg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    room0_r      <= room[0];
    room1_r      <= room[1];
    fwd_valid_r  <= fwd_v;
    fwd_word_r   <= fwd_word_nxt;
    fwd_source_r <= fwd_src;
    got0_valid_r <= rsp_ctl[0].pop;
    got0_word_r  <= got0_word_nxt;
    got1_valid_r <= rsp_ctl[1].pop;
    got1_word_r  <= got1_word_nxt;
    lost_r       <= lost_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_room0      = room0_r;
  assign out_room1      = room1_r;
  assign out_fwd_valid  = fwd_valid_r;
  assign out_fwd_word   = fwd_word_r;
  assign out_fwd_source = fwd_source_r;
  assign out_out0_valid = got0_valid_r;
  assign out_out0_word  = got0_word_r;
  assign out_out1_valid = got1_valid_r;
  assign out_out1_word  = got1_word_r;
  assign out_lost       = lost_r;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the two-port memory arbiter: queued stimulus, predictor, monitor.
module testbench;

  localparam int PORT_W      = tpma_pkg::PORT_W;
  localparam int RQD         = tpma_pkg::REQ_DEPTH_DEF;
  localparam int SQD         = tpma_pkg::RSP_DEPTH_DEF;
  localparam int TQD         = tpma_pkg::TAG_DEPTH_DEF;
  localparam int WW          = tpma_pkg::WORD_WIDTH_DEF;
  localparam logic [PORT_W-1:0] WORD_MASK = {PORT_W{1'b1}} >> (PORT_W - WW);
  localparam int RANDOM_ITEMS = 1325;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic              req0_valid;
    logic [PORT_W-1:0] req0_word;
    logic              req1_valid;
    logic [PORT_W-1:0] req1_word;
    logic              poll0;
    logic              poll1;
    logic              ram_ready;
    logic              ram_rsp_valid;
    logic [PORT_W-1:0] ram_rsp_word;
  } arb_item_t;

  typedef struct packed {
    logic              room0;
    logic              room1;
    logic              fwd_valid;
    logic [PORT_W-1:0] fwd_word;
    logic              fwd_source;
    logic              out0_valid;
    logic [PORT_W-1:0] out0_word;
    logic              out1_valid;
    logic [PORT_W-1:0] out1_word;
    logic              lost;
  } arb_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_req0_valid = 1'b0;
  logic [PORT_W-1:0] in_req0_word = '0;
  logic              in_req1_valid = 1'b0;
  logic [PORT_W-1:0] in_req1_word = '0;
  logic              in_poll0 = 1'b0;
  logic              in_poll1 = 1'b0;
  logic              in_ram_ready = 1'b0;
  logic              in_ram_rsp_valid = 1'b0;
  logic [PORT_W-1:0] in_ram_rsp_word = '0;
  logic              out_valid;
  logic              out_room0;
  logic              out_room1;
  logic              out_fwd_valid;
  logic [PORT_W-1:0] out_fwd_word;
  logic              out_fwd_source;
  logic              out_out0_valid;
  logic [PORT_W-1:0] out_out0_word;
  logic              out_out1_valid;
  logic [PORT_W-1:0] out_out1_word;
  logic              out_lost;

  two_port_memory_arbiter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req0_valid    (in_req0_valid),
    .in_req0_word     (in_req0_word),
    .in_req1_valid    (in_req1_valid),
    .in_req1_word     (in_req1_word),
    .in_poll0         (in_poll0),
    .in_poll1         (in_poll1),
    .in_ram_ready     (in_ram_ready),
    .in_ram_rsp_valid (in_ram_rsp_valid),
    .in_ram_rsp_word  (in_ram_rsp_word),
    .out_valid        (out_valid),
    .out_room0        (out_room0),
    .out_room1        (out_room1),
    .out_fwd_valid    (out_fwd_valid),
    .out_fwd_word     (out_fwd_word),
    .out_fwd_source   (out_fwd_source),
    .out_out0_valid   (out_out0_valid),
    .out_out0_word    (out_out0_word),
    .out_out1_valid   (out_out1_valid),
    .out_out1_word    (out_out1_word),
    .out_lost         (out_lost)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  arb_item_t   pending_items[$];
  arb_result_t expected_results[$];
  arb_item_t   on_bus;
  arb_result_t predicted;
  arb_result_t oldest;
  int          items_sent = 0;
  int          mismatches = 0;
  int          idle_pct;

  // Shadow copy of the queues and the round-robin pointer.
  logic [PORT_W-1:0] req_store[2][RQD];
  int                req_head[2];
  int                req_count[2];
  logic [PORT_W-1:0] rsp_store[2][SQD];
  int                rsp_head[2];
  int                rsp_count[2];
  bit                tag_store[TQD];
  int                tag_head = 0;
  int                tag_count = 0;
  bit                favored = 1'b0;

  initial begin
    req_head = '{0, 0};
    req_count = '{0, 0};
    rsp_head = '{0, 0};
    rsp_count = '{0, 0};
  end

  task automatic arbitrate(input arb_item_t it, output arb_result_t r);
    bit                rv[2];
    logic [PORT_W-1:0] rw[2];
    bit                pl[2];
    bit                gv[2];
    logic [PORT_W-1:0] gw[2];
    bit                owner;
    bit                fav;
    bit                oth;
    bit                win;
    bit                src;
    int                s;
    rv[0] = it.req0_valid;
    rv[1] = it.req1_valid;
    rw[0] = it.req0_word;
    rw[1] = it.req1_word;
    pl[0] = it.poll0;
    pl[1] = it.poll1;
    gv = '{1'b0, 1'b0};
    gw = '{'0, '0};
    r = '0;
    for (s = 0; s < 2; s++) begin
      if (rv[s]) begin
        if (req_count[s] == RQD) begin
          r.lost = 1'b1;
        end else begin
          req_store[s][(req_head[s] + req_count[s]) % RQD] = rw[s] & WORD_MASK;
          req_count[s]++;
        end
      end
    end
    for (s = 0; s < 2; s++) begin
      if (pl[s] && rsp_count[s] > 0) begin
        gv[s] = 1'b1;
        gw[s] = rsp_store[s][rsp_head[s]];
        rsp_head[s] = (rsp_head[s] + 1) % SQD;
        rsp_count[s]--;
      end
    end
    // route to the oldest tag owner; the tag is popped even if the queue is full
    if (it.ram_rsp_valid) begin
      if (tag_count == 0) begin
        r.lost = 1'b1;
      end else begin
        owner = tag_store[tag_head];
        tag_head = (tag_head + 1) % TQD;
        tag_count--;
        if (rsp_count[owner] == SQD) begin
          r.lost = 1'b1;
        end else begin
          rsp_store[owner][(rsp_head[owner] + rsp_count[owner]) % SQD] =
            it.ram_rsp_word & WORD_MASK;
          rsp_count[owner]++;
        end
      end
    end
    if (it.ram_ready && tag_count < TQD) begin
      fav = favored;
      oth = ~favored;
      win = 1'b0;
      src = 1'b0;
      if (req_count[fav] > 0) begin
        src = fav;
        win = 1'b1;
        favored = oth;
      end else if (req_count[oth] > 0) begin
        src = oth;
        win = 1'b1;
      end
      if (win) begin
        r.fwd_valid = 1'b1;
        r.fwd_source = src;
        r.fwd_word = req_store[src][req_head[src]];
        req_head[src] = (req_head[src] + 1) % RQD;
        req_count[src]--;
        tag_store[(tag_head + tag_count) % TQD] = src;
        tag_count++;
      end
    end
    r.room0 = (req_count[0] < RQD);
    r.room1 = (req_count[1] < RQD);
    r.out0_valid = gv[0];
    r.out0_word = gw[0];
    r.out1_valid = gv[1];
    r.out1_word = gw[1];
  endtask

  function automatic arb_item_t make_item(bit r0v, logic [PORT_W-1:0] r0w, bit r1v,
                                          logic [PORT_W-1:0] r1w, bit p0, bit p1, bit rdy,
                                          bit rspv, logic [PORT_W-1:0] rspw);
    arb_item_t it;
    it.req0_valid = r0v;
    it.req0_word = r0w;
    it.req1_valid = r1v;
    it.req1_word = r1w;
    it.poll0 = p0;
    it.poll1 = p1;
    it.ram_ready = rdy;
    it.ram_rsp_valid = rspv;
    it.ram_rsp_word = rspw;
    return it;
  endfunction

  function automatic logic [PORT_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3))
      0:       return 5;
      1:       return 30;
      2:       return 60;
      default: return 95;
    endcase
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Driver: retire the item on the bus when accepted, then offer the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        arbitrate(on_bus, predicted);
        expected_results.push_back(predicted);
        items_sent++;
      end
      if (!start || !busy) begin
        case ((items_sent / 200) % 4)
          0:       idle_pct = 0;
          1:       idle_pct = 62;
          2:       idle_pct = 0;
          default: idle_pct = 38;
        endcase
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          on_bus = pending_items.pop_front();
          in_req0_valid    <= on_bus.req0_valid;
          in_req0_word     <= on_bus.req0_word;
          in_req1_valid    <= on_bus.req1_valid;
          in_req1_word     <= on_bus.req1_word;
          in_poll0         <= on_bus.poll0;
          in_poll1         <= on_bus.poll1;
          in_ram_ready     <= on_bus.ram_ready;
          in_ram_rsp_valid <= on_bus.ram_rsp_valid;
          in_ram_rsp_word  <= on_bus.ram_rsp_word;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(string name, logic [PORT_W-1:0] want,
                                        logic [PORT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: every strobed result must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result strobed with no item outstanding");
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        compare_field("room0", PORT_W'(oldest.room0), PORT_W'(out_room0));
        compare_field("room1", PORT_W'(oldest.room1), PORT_W'(out_room1));
        compare_field("fwd_valid", PORT_W'(oldest.fwd_valid), PORT_W'(out_fwd_valid));
        compare_field("fwd_word", oldest.fwd_word, out_fwd_word);
        compare_field("fwd_source", PORT_W'(oldest.fwd_source), PORT_W'(out_fwd_source));
        compare_field("out0_valid", PORT_W'(oldest.out0_valid), PORT_W'(out_out0_valid));
        compare_field("out0_word", oldest.out0_word, out_out0_word);
        compare_field("out1_valid", PORT_W'(oldest.out1_valid), PORT_W'(out_out1_valid));
        compare_field("out1_word", oldest.out1_word, out_out1_word);
        compare_field("lost", PORT_W'(oldest.lost), PORT_W'(out_lost));
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int k;
    int burst;
    int queued;
    int p_r0, p_r1, p_p0, p_p1, p_rdy, p_rsp;
    // idle step, then polls of empty queues together with a response that has no tag
    pending_items.push_back(make_item(1'b0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    pending_items.push_back(make_item(1'b0, '1, 1'b0, '1, 1'b1, 1'b1, 1'b0, 1'b1, '1));
    // fill both request queues past full while memory is not ready
    for (k = 0; k < RQD + 1; k++) begin
      pending_items.push_back(make_item(1'b1, k[0] ? '1 : '0, 1'b1, k[0] ? '0 : '1,
                                        1'b0, 1'b0, 1'b0, 1'b0, '0));
    end
    // forward until the tag FIFO is full, then one more that must stall
    for (k = 0; k < TQD + 1; k++) begin
      pending_items.push_back(make_item(1'b0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b1, 1'b0, '0));
    end
    // route responses back to alternating owners, then take some
    for (k = 0; k < 6; k++) begin
      pending_items.push_back(make_item(1'b0, '0, 1'b0, '0, k >= 4, k >= 4, 1'b0, 1'b1,
                                        k[0] ? '1 : {$urandom, $urandom}));
    end
    // random bursts, each with its own traffic mix
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      burst = $urandom_range(80, 20);
      p_r0 = pick_pct();
      p_r1 = pick_pct();
      p_p0 = pick_pct();
      p_p1 = pick_pct();
      p_rdy = pick_pct();
      p_rsp = pick_pct();
      for (k = 0; k < burst; k++) begin
        pending_items.push_back(make_item(chance(p_r0), rand_word(), chance(p_r1),
                                          rand_word(), chance(p_p0), chance(p_p1),
                                          chance(p_rdy), chance(p_rsp), rand_word()));
        queued++;
      end
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do begin
      @(posedge clk);
    end while (pending_items.size() != 0 || start || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- two_port_memory_arbiter.f -----
design/tpma_pkg.sv
design/tpma_fifo.sv
design/two_port_memory_arbiter.sv
sim/testbench.sv
